@@ hdl/fbik_pkg.sv @@
// Package for the five-bar leg height IK unit: constants, types, arctangent table.
// No dependencies.
package fbik_pkg;

  localparam int RcW      = 11;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;
  localparam int DegW     = 9;
  localparam int FiltW    = 24;
  localparam int BaseOffsetDefault = 0;

  localparam logic [CfgIdxW-1:0] REG_RC_MIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RC_MAX      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LINK_ONE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LINK_TWO    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LINK_THREE  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LINK_FOUR   = 3'd7;

  localparam int CordicSteps = 16;
  localparam logic signed [19:0] QuarterPi = 20'sd51472;
  localparam logic signed [19:0] TwoPi     = 20'sd411775;
  localparam int GainQ16  = 6554;
  localparam int ServoMax = 300;

  typedef struct packed {
    logic [RcW-1:0]   rc_min;
    logic [RcW-1:0]   rc_max;
    logic [ByteW-1:0] height_low;
    logic [ByteW-1:0] height_high;
    logic [ByteW-1:0] link_one;
    logic [ByteW-1:0] link_two;
    logic [ByteW-1:0] link_three;
    logic [ByteW-1:0] link_four;
  } cfg_t;

  typedef struct packed {
    logic [DegW-1:0]  left_front_deg;
    logic [DegW-1:0]  left_rear_deg;
    logic [DegW-1:0]  right_front_deg;
    logic [DegW-1:0]  right_rear_deg;
    logic [ByteW-1:0] height_now;
    logic             reach_ok;
  } result_t;

  function automatic logic [16:0] atan_entry(input logic [3:0] i);
    logic [16:0] v;
    unique case (i)
      4'd0: v = 17'd51472;  4'd1: v = 17'd30386;  4'd2: v = 17'd16055;
      4'd3: v = 17'd8150;   4'd4: v = 17'd4091;   4'd5: v = 17'd2047;
      4'd6: v = 17'd1024;   4'd7: v = 17'd512;    4'd8: v = 17'd256;
      4'd9: v = 17'd128;    4'd10: v = 17'd64;    4'd11: v = 17'd32;
      4'd12: v = 17'd16;    4'd13: v = 17'd8;     4'd14: v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/fbik_stream_if.sv @@
// Valid/ready channel carrying one payload of parametric width.
// Depends on nothing.
interface fbik_stream_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/five_bar_leg_height_ik_unit.sv @@
// Top level of the five-bar leg height IK unit.
// Depends on fbik_pkg, fbik_stream_if, fbik_front, fbik_queue, fbik_back.
//
// Usage: one raw RC height sample enters on in_ch (valid/ready); one result with
// four servo angles, the filtered height and a reach flag leaves on out_ch.
// Configuration is a write port (cfg_we, cfg_idx, cfg_data), written while idle.
// Sequence: the front accepts a request, runs 20 bit-serial divide steps and then
// pushes the demand into the queue. The back end picks it up, filters, computes the
// geometry, then for each joint runs the discriminant, the square root and two roots
// (load, 16 CORDIC steps, pick), and converts to degrees. The CORDIC steps are skipped
// for a root whose numerator is zero. The back end takes a new request only after
// its result has left, each pass going through the shared square root and CORDIC unit.
// Reset (rst_n low, synchronous) loads the register defaults and clears the
// filter state. When the receiver stalls the result holds on out_ch, the queue
// takes two more requests and the front holds a third, after which in_ch.ready stays low.
module five_bar_leg_height_ik_unit import fbik_pkg::*; #(
  parameter int BASE_OFFSET = BaseOffsetDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  fbik_stream_if.sink         in_ch,
  fbik_stream_if.source       out_ch
);
  cfg_t             cfg_r;
  logic             qw_valid, qw_ready, qr_valid, qr_ready;
  logic [ByteW-1:0] qw_data, qr_data;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rc_min: 11'd172, rc_max: 11'd1811, height_low: 8'd70,
                 height_high: 8'd130, link_one: 8'd60, link_two: 8'd100,
                 link_three: 8'd100, link_four: 8'd60};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RC_MIN:      cfg_r.rc_min      <= cfg_data;
        REG_RC_MAX:      cfg_r.rc_max      <= cfg_data;
        REG_HEIGHT_LOW:  cfg_r.height_low  <= cfg_data[ByteW-1:0];
        REG_HEIGHT_HIGH: cfg_r.height_high <= cfg_data[ByteW-1:0];
        REG_LINK_ONE:    cfg_r.link_one    <= cfg_data[ByteW-1:0];
        REG_LINK_TWO:    cfg_r.link_two    <= cfg_data[ByteW-1:0];
        REG_LINK_THREE:  cfg_r.link_three  <= cfg_data[ByteW-1:0];
        REG_LINK_FOUR:   cfg_r.link_four   <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  fbik_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_rc_value(in_ch.data),
    .q_valid(qw_valid), .q_ready(qw_ready), .q_demand(qw_data)
  );

  fbik_queue u_queue (
    .clk, .rst_n,
    .wr_valid(qw_valid), .wr_ready(qw_ready), .wr_data(qw_data),
    .rd_valid(qr_valid), .rd_ready(qr_ready), .rd_data(qr_data)
  );

  fbik_back #(.BASE_OFFSET(BASE_OFFSET)) u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_valid(qr_valid), .q_ready(qr_ready), .q_demand(qr_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.data = res;
endmodule

@@ hdl/fbik_front.sv @@
// Front end: accept samples, clamp and map to height demand, push to the queue.
// Depends on fbik_pkg. The demand divide runs bit-serially (20 steps).
module fbik_front import fbik_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RcW-1:0]   in_rc_value,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [ByteW-1:0] q_demand
);
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_PUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [RcW-1:0]    v_clamp;
  logic [19:0]       num_r;        // (v-lo)*|hh-hl| up to 2047*255
  logic [RcW-1:0]    den_r;
  logic [19:0]       quo_r;
  logic [RcW:0]      rem_r;
  logic [4:0]        cnt_r;
  logic              neg_r;
  logic [ByteW-1:0]  base_r;
  logic [ByteW-1:0]  dem_r;
  logic [RcW+1:0]    rem_sh;
  logic [ByteW:0]    span;
  logic [ByteW-1:0]  span_abs;
  logic              q_bit;
  logic [ByteW-1:0]  quo_lo;

  always_comb begin
    if (in_rc_value < cfg.rc_min)      v_clamp = cfg.rc_min;
    else if (in_rc_value > cfg.rc_max) v_clamp = cfg.rc_max;
    else                               v_clamp = in_rc_value;
    span     = {1'b0, cfg.height_high} - {1'b0, cfg.height_low};
    span_abs = span[ByteW] ? ByteW'(-span) : span[ByteW-1:0];
    rem_sh   = {rem_r, num_r[19]};
    q_bit    = (rem_sh >= {2'b0, den_r});
    // include the bit decided this cycle
    quo_lo   = {quo_r[ByteW-2:0], q_bit};
  end

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_PUSH);
  assign q_demand = dem_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 5'd19) state_nxt = S_PUSH;
      S_PUSH: if (q_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      num_r  <= 20'(RcW'(v_clamp - cfg.rc_min) * span_abs);
      den_r  <= RcW'(cfg.rc_max - cfg.rc_min);
      neg_r  <= span[ByteW];
      base_r <= cfg.height_low;
      quo_r  <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (state_r == S_DIV) begin
      // restoring divide, one quotient bit per cycle
      if (q_bit) begin
        rem_r <= (RcW+1)'(rem_sh - {2'b0, den_r});
        quo_r <= {quo_r[18:0], 1'b1};
      end else begin
        rem_r <= rem_sh[RcW:0];
        quo_r <= {quo_r[18:0], 1'b0};
      end
      num_r <= {num_r[18:0], 1'b0};
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd19) begin
        if (den_r == '0) dem_r <= base_r;
        else if (neg_r)  dem_r <= base_r - quo_lo;
        else             dem_r <= base_r + quo_lo;
      end
    end
  end
endmodule

@@ hdl/fbik_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on fbik_pkg.
module fbik_queue import fbik_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [ByteW-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [ByteW-1:0] rd_data
);
  logic [ByteW-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hdl/fbik_back.sv @@
// Back end: height filter, five-bar IK via shared sqrt and CORDIC, degree output.
// Depends on fbik_pkg. Sequencer over a shared isqrt and CORDIC.
module fbik_back import fbik_pkg::*; #(
  parameter int BASE_OFFSET = BaseOffsetDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [ByteW-1:0] q_demand,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);
  localparam logic [3:0]
    S_IDLE = 4'd0, S_FILT = 4'd1, S_GEOM = 4'd2, S_DISC = 4'd3, S_SQRT = 4'd4,
    S_ATAN = 4'd5, S_NEXT = 4'd6, S_PICK = 4'd7, S_DEG = 4'd8, S_OUT = 4'd9;
  localparam logic [7:0] L5 = 8'(BASE_OFFSET);
  // degrees = |rad| * 36000 / (628 * 2^16), as a reciprocal scaled by 2^40
  localparam logic [29:0] DegRecip = 30'd961751236;

  logic [3:0]          state_r;
  logic [FiltW-1:0]    filt_r;
  logic [ByteW-1:0]    dem_r;
  logic signed [47:0]  diff_mul;
  logic signed [25:0]  fsum;
  logic [15:0]         h;
  logic signed [31:0]  sq_v, b_v, c_v, d_v, e_v, f_v;
  logic signed [31:0]  b_r, c_r, e_r, dq_r, f_r;
  logic [63:0]         dwork_r, root_r, bit_r;
  logic                ok_a_r, ok_b_r;
  logic                side_r;   // 0 alpha, 1 beta
  logic                root_sel_r;
  logic [4:0]          it_r;
  logic signed [40:0]  cx_r, cy_r;
  logic signed [20:0]  cz_r;
  logic signed [20:0]  ap_r, am_r, bp_r, bm_r;
  logic signed [31:0]  p_sel, q_sel, s_sel;
  logic signed [63:0]  pp, qq, ss;
  logic signed [31:0]  num_v;
  logic signed [20:0]  z2;
  logic signed [20:0]  adeg_r, bdeg_r;
  logic signed [40:0]  xs, ys;
  logic                sel_is_a;

  function automatic logic signed [20:0] to_deg(input logic signed [20:0] r);
    logic [20:0] mag;
    logic [50:0] prod;
    mag  = r[20] ? 21'(-r) : 21'(r);
    prod = 51'(mag) * 51'(DegRecip);
    return r[20] ? -21'(prod[50:40]) : 21'(prod[50:40]);
  endfunction

  function automatic logic [DegW-1:0] clamp_srv(input logic signed [20:0] v);
    if (v < 0) return '0;
    if (v > 21'sd300) return 9'd300;
    return v[DegW-1:0];
  endfunction

  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    diff_mul = (48'(signed'({1'b0, dem_r, 16'b0})) - 48'(signed'({1'b0, filt_r})))
               * 48'sd6554 + 48'sd32768;
    fsum     = 26'(signed'({1'b0, filt_r})) + 26'(diff_mul >>> 16);
    h        = filt_r[23:8];
    sq_v     = 32'((32'(h) * 32'(h)) >> 8);
    b_v      = 32'(2 * 32'(h) * 32'(cfg.link_one));
    c_v      = sq_v + (32'(cfg.link_one) * cfg.link_one - 32'(cfg.link_two) * cfg.link_two) * 256;
    d_v      = -32'sd2 * 32'(cfg.link_four) * 32'(L5) * 256;
    e_v      = 32'(2 * 32'(cfg.link_four) * 32'(h));
    f_v      = sq_v + (32'(L5) * L5 + 32'(cfg.link_four) * cfg.link_four
                       - 32'(cfg.link_three) * cfg.link_three) * 256;
    sel_is_a = !side_r;
    p_sel    = sel_is_a ? b_r : e_r;
    q_sel    = sel_is_a ? c_r : dq_r;
    s_sel    = 32'(root_r);
    num_v    = root_sel_r ? p_sel - s_sel : p_sel + s_sel;
    pp = 64'(b_r) * 64'(b_r);
    qq = 64'(c_r) * 64'(c_r);
    ss = 64'(e_r) * 64'(e_r) + 64'(d_v) * 64'(d_v) - 64'(f_r) * 64'(f_r);
    xs = cx_r >>> it_r[3:0];
    ys = cy_r >>> it_r[3:0];
    z2 = 21'(cz_r <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      filt_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          dem_r <= q_demand; state_r <= S_FILT;
        end
        S_FILT: begin
          if (fsum < 0) filt_r <= '0;
          else if (fsum > 26'sh0FFFFFF) filt_r <= 24'hFFFFFF;
          else filt_r <= fsum[23:0];
          state_r <= S_GEOM;
        end
        S_GEOM: begin
          b_r <= b_v; c_r <= c_v; e_r <= e_v; f_r <= f_v; dq_r <= d_v + f_v;
          side_r <= 1'b0; state_r <= S_DISC;
        end
        S_DISC: begin
          if (!side_r) begin
            ok_a_r  <= (pp - qq) >= 0;
            dwork_r <= ((pp - qq) < 0) ? '0 : 64'(pp - qq);
          end else begin
            ok_b_r  <= ss >= 0;
            dwork_r <= (ss < 0) ? '0 : 64'(ss);
          end
          root_r <= '0; bit_r <= 64'h4000_0000_0000_0000;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            root_sel_r <= 1'b0; state_r <= S_NEXT;
          end else begin
            if (dwork_r >= root_r + bit_r) begin
              dwork_r <= dwork_r - (root_r + bit_r);
              root_r  <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_NEXT: begin
          // load CORDIC for the current root
          it_r <= '0; cz_r <= '0;
          if (q_sel < 0) begin
            cx_r <= -41'(q_sel); cy_r <= -41'(num_v);
          end else begin
            cx_r <= 41'(q_sel);  cy_r <= 41'(num_v);
          end
          state_r <= (num_v == 0) ? S_PICK : S_ATAN;
        end
        S_ATAN: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs;
            cz_r <= cz_r + 21'(atan_entry(it_r[3:0]));
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs;
            cz_r <= cz_r - 21'(atan_entry(it_r[3:0]));
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CordicSteps - 1)) state_r <= S_PICK;
        end
        S_PICK: begin
          if (!side_r) begin
            if (!root_sel_r) ap_r <= z2 < 0 ? z2 + 21'(TwoPi) : z2;
            else             am_r <= z2 < 0 ? z2 + 21'(TwoPi) : z2;
          end else begin
            if (!root_sel_r) bp_r <= z2; else bm_r <= z2;
          end
          if (!root_sel_r) begin
            root_sel_r <= 1'b1; state_r <= S_NEXT;
          end else if (!side_r) begin
            side_r <= 1'b1; state_r <= S_DISC;
          end else begin
            state_r <= S_DEG;
          end
        end
        S_DEG: begin
          adeg_r  <= to_deg((ap_r >= 21'(QuarterPi)) ? ap_r : am_r);
          bdeg_r  <= to_deg((bp_r >= 0 && bp_r <= 21'(QuarterPi)) ? bp_r : bm_r);
          state_r <= S_OUT;
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.left_front_deg  = clamp_srv(21'sd90 + bdeg_r);
    res.left_rear_deg   = clamp_srv(21'sd90 + adeg_r);
    res.right_front_deg = clamp_srv(21'sd270 - bdeg_r);
    res.right_rear_deg  = clamp_srv(21'sd270 - adeg_r);
    res.height_now      = filt_r[23:16];
    res.reach_ok        = ok_a_r && ok_b_r;
  end
endmodule

@@ hdl/fbik_checker.sv @@
// Port-level checks for the five-bar leg height IK unit, bound to the top level.
// Depends on fbik_pkg.
module fbik_checker import fbik_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [$bits(result_t)-1:0]  out_data
);
  result_t r;
  assign r = out_data;

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (r.left_front_deg <= 9'd300 && r.right_rear_deg <= 9'd300))
    else $error("servo angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind five_bar_leg_height_ik_unit fbik_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);

@@ tb/five_bar_leg_height_ik_unit_tb.sv @@
// Testbench for five_bar_leg_height_ik_unit: a directed table, then random samples under
// several register settings, each result checked against a fixed-point leg height predictor.
// Depends on fbik_pkg, fbik_stream_if and the unit itself.
`timescale 1ns / 100ps

module five_bar_leg_height_ik_unit_tb;
  import fbik_pkg::*;

  localparam int CycleLimit  = 3000000;
  localparam int DrainCycles = 200;
  localparam int RandPhases  = 6;
  localparam int PhaseItems  = 205;
  localparam longint GainQ    = 6554;
  localparam longint DegNum   = 36000;
  localparam longint DegDen   = 41156608;
  localparam longint FiltTop  = 64'hFFFFFF;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    logic                has_height;
    logic [ByteW-1:0]    height;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  fbik_stream_if #(.W(RcW)) in_if (clk);
  fbik_stream_if #(.W($bits(result_t))) out_if (clk);

  five_bar_leg_height_ik_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  always #5 clk = ~clk;

  cfg_t    leg_cfg;
  longint  filt_height;
  result_t pending_angles[$];
  logic [ByteW:0] pending_table[$];
  int      mismatches = 0;
  int      results_seen = 0;
  longint  cycles = 0;
  bit      gaps_on = 1'b1;

  longint atan_q16[CordicSteps] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint ratio_atan(longint num, longint den);
    longint x, y, z, xs, ys;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num == 0) return 0;
    x = den;
    y = num;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += atan_q16[i];
      end else begin
        x -= ys;
        y += xs;
        z -= atan_q16[i];
      end
    end
    return z;
  endfunction

  function automatic logic [DegW-1:0] servo_deg(longint v);
    if (v < 0) return '0;
    if (v > ServoMax) return DegW'(ServoMax);
    return DegW'(v);
  endfunction

  // Advance the filter and solve the leg for one accepted sample.
  function automatic result_t predict_leg(logic [RcW-1:0] raw);
    result_t r;
    longint lo, hi, hl, hh, v, demand, diff, h, sq;
    longint l1, l2, l3, l4, l5, b, c, d, e, f;
    longint disc_a, disc_b, sa, sb, ap, am, bp, bm, alpha, beta, adeg, bdeg;
    lo = leg_cfg.rc_min; hi = leg_cfg.rc_max;
    hl = leg_cfg.height_low; hh = leg_cfg.height_high;
    l1 = leg_cfg.link_one; l2 = leg_cfg.link_two;
    l3 = leg_cfg.link_three; l4 = leg_cfg.link_four;
    l5 = BaseOffsetDefault;
    v = raw;
    v = v < lo ? lo : (v > hi ? hi : v);
    demand = (hi == lo) ? hl : (v - lo) * (hh - hl) / (hi - lo) + hl;
    diff = demand * 65536 - filt_height;
    filt_height += (diff * GainQ + 32768) >>> 16;
    if (filt_height < 0) filt_height = 0;
    if (filt_height > FiltTop) filt_height = FiltTop;

    h = filt_height >>> 8;
    sq = (h * h) >>> 8;
    b = 2 * h * l1;
    c = sq + (l1 * l1 - l2 * l2) * 256;
    d = -2 * l4 * l5 * 256;
    e = 2 * l4 * h;
    f = sq + (l5 * l5 + l4 * l4 - l3 * l3) * 256;
    disc_a = b * b - c * c;
    disc_b = d * d + e * e - f * f;
    sa = disc_a >= 0 ? root_floor(disc_a) : 0;
    sb = disc_b >= 0 ? root_floor(disc_b) : 0;
    ap = 2 * ratio_atan(b + sa, c);
    am = 2 * ratio_atan(b - sa, c);
    bp = 2 * ratio_atan(e + sb, d + f);
    bm = 2 * ratio_atan(e - sb, d + f);
    if (ap < 0) ap += TwoPi;
    if (am < 0) am += TwoPi;
    alpha = (ap >= QuarterPi) ? ap : am;
    beta = (bp >= 0 && bp <= QuarterPi) ? bp : bm;
    adeg = alpha * DegNum / DegDen;
    bdeg = beta * DegNum / DegDen;

    r.left_front_deg  = servo_deg(90 + bdeg);
    r.left_rear_deg   = servo_deg(90 + adeg);
    r.right_front_deg = servo_deg(270 - bdeg);
    r.right_rear_deg  = servo_deg(270 - adeg);
    r.height_now      = ByteW'(filt_height >> 16);
    r.reach_ok        = disc_a >= 0 && disc_b >= 0;
    return r;
  endfunction

  // Call right after a rising edge; leaves cfg_we high for the caller to drop.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      REG_RC_MIN:      leg_cfg.rc_min = value;
      REG_RC_MAX:      leg_cfg.rc_max = value;
      REG_HEIGHT_LOW:  leg_cfg.height_low = value[ByteW-1:0];
      REG_HEIGHT_HIGH: leg_cfg.height_high = value[ByteW-1:0];
      REG_LINK_ONE:    leg_cfg.link_one = value[ByteW-1:0];
      REG_LINK_TWO:    leg_cfg.link_two = value[ByteW-1:0];
      REG_LINK_THREE:  leg_cfg.link_three = value[ByteW-1:0];
      default:         leg_cfg.link_four = value[ByteW-1:0];
    endcase
    @(posedge clk);
  endtask

  // Hold the sender until every result is back, then let the pipe settle.
  task automatic drain_unit();
    in_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_sample(logic [RcW-1:0] raw, bit has_height, logic [ByteW-1:0] height);
    result_t r;
    int gap;
    in_if.valid <= 1'b1;
    in_if.data <= raw;
    do @(posedge clk); while (!in_if.ready);
    r = predict_leg(raw);
    pending_angles.push_back(r);
    pending_table.push_back({has_height, height});
    gap = 0;
    if (gaps_on) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 3);
        default:       gap = $urandom_range(10, 60);
      endcase
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  stim_row_t directed[$] = '{
    '{ROW_CFG, REG_HEIGHT_LOW, 11'd0, 1'b0, 8'd0},
    '{ROW_CFG, REG_HEIGHT_HIGH, 11'd0, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_TWO, 11'd60, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_THREE, 11'd60, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd500, 1'b1, 8'd0},    // zero height: zero denominators
    '{ROW_CFG, REG_HEIGHT_LOW, 11'd70, 1'b0, 8'd0},
    '{ROW_CFG, REG_HEIGHT_HIGH, 11'd130, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_TWO, 11'd100, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_THREE, 11'd100, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd172, 1'b1, 8'd7},
    '{ROW_SAMPLE, '0, 11'd0, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2047, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd1811, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd1000, 1'b0, 8'd0},
    '{ROW_CFG, REG_RC_MIN, 11'd1000, 1'b0, 8'd0},   // equal bounds
    '{ROW_CFG, REG_RC_MAX, 11'd1000, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd5, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2047, 1'b0, 8'd0},
    '{ROW_CFG, REG_RC_MIN, 11'd1500, 1'b0, 8'd0},   // inverted bounds
    '{ROW_CFG, REG_RC_MAX, 11'd300, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd100, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2000, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd900, 1'b0, 8'd0},
    '{ROW_CFG, REG_RC_MIN, 11'd0, 1'b0, 8'd0},
    '{ROW_CFG, REG_RC_MAX, 11'd2047, 1'b0, 8'd0},
    '{ROW_CFG, REG_HEIGHT_HIGH, 11'd255, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_ONE, 11'd255, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_TWO, 11'd1, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_THREE, 11'd255, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_FOUR, 11'd1, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2047, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2047, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd2047, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_ONE, 11'd1, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_TWO, 11'd255, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_THREE, 11'd1, 1'b0, 8'd0},
    '{ROW_CFG, REG_LINK_FOUR, 11'd255, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd0, 1'b0, 8'd0},
    '{ROW_SAMPLE, '0, 11'd1024, 1'b0, 8'd0}
  };

  // Receiver: random stalls, one long hold-off, and the result check.
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    result_t got, want;
    logic [ByteW:0] tab;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = result_t'(out_if.data);
      results_seen++;
      if (pending_angles.size() == 0) begin
        if (mismatches++ < 10) $display("unexpected result %p", got);
      end else begin
        want = pending_angles.pop_front();
        tab = pending_table.pop_front();
        if (tab[ByteW] && got.height_now != tab[ByteW-1:0]) begin
          if (mismatches++ < 10)
            $display("result %0d height mismatch: expected %0d, got %0d",
                     results_seen, tab[ByteW-1:0], got.height_now);
        end else if (got.left_front_deg != want.left_front_deg
            || got.left_rear_deg != want.left_rear_deg
            || got.right_front_deg != want.right_front_deg
            || got.right_rear_deg != want.right_rear_deg
            || got.height_now != want.height_now
            || got.reach_ok != want.reach_ok) begin
          if (mismatches++ < 10)
            $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
        end
      end
    end
    if (!long_hold_done && results_seen == 60) begin
      long_hold_done = 1'b1;
      stall_left = 800;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!gaps_on) begin
      out_if.ready <= 1'b1;
    end else begin
      case ($urandom_range(19))
        0:          stall_left = $urandom_range(10, 80);
        1, 2, 3, 4: stall_left = $urandom_range(1, 4);
        default:    stall_left = 0;
      endcase
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    leg_cfg = '{rc_min: 11'd172, rc_max: 11'd1811, height_low: 8'd70, height_high: 8'd130,
                link_one: 8'd60, link_two: 8'd100, link_three: 8'd100, link_four: 8'd60};
    filt_height = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i-1].kind != ROW_CFG) drain_unit();
        write_reg(directed[i].idx, directed[i].value);
        if (i + 1 < directed.size() && directed[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_sample(directed[i].value[RcW-1:0], directed[i].has_height, directed[i].height);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      drain_unit();
      gaps_on = (p != 2);
      for (int k = 0; k < 8; k++) begin
        logic [CfgDataW-1:0] val;
        case (p)
          0: val = (k == 0) ? 11'd172 : (k == 1) ? 11'd1811 : (k == 2) ? 11'd70 :
                   (k == 3) ? 11'd130 : (k == 4 || k == 7) ? 11'd60 : 11'd100;
          1: val = (k < 2) ? (k == 0 ? 11'd0 : 11'd2047) : (k < 4) ? (k == 2 ? 11'd0 : 11'd255)
                   : 11'd255;
          default: begin
            if (k == 0 || k == 1) val = CfgDataW'($urandom_range(2047));
            else if (k < 4) val = CfgDataW'($urandom_range(255));
            else val = CfgDataW'($urandom_range(1, 255));
          end
        endcase
        // Keep most random phases with ordered bounds so the map spans its range.
        if (p > 2 && k == 1 && val < leg_cfg.rc_min && $urandom_range(3) != 0)
          val = CfgDataW'(leg_cfg.rc_min + $urandom_range(2047 - leg_cfg.rc_min));
        write_reg(k[CfgIdxW-1:0], val);
      end
      cfg_we <= 1'b0;
      for (int n = 0; n < PhaseItems; n++)
        send_sample(RcW'($urandom_range(2047)), 1'b0, 8'd0);
    end

    in_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
